### rtl/core/round_robin_schedule_simulator_defines.svh
// Assertion macros for the round-robin schedule simulator.
`ifndef ROUND_ROBIN_SCHEDULE_SIMULATOR_DEFINES_SVH
`define ROUND_ROBIN_SCHEDULE_SIMULATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define RRS_ASSERT_ALWAYS(label, clk, rstn, expr) \
    label: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
        else $error("rrs invariant violated");
`define RRS_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("rrs implication violated");
`else
`define RRS_ASSERT_ALWAYS(label, clk, rstn, expr)
`define RRS_ASSERT_IMPLY(label, clk, rstn, ante, cons)
`endif
`endif

### rtl/core/rrs_pkg.sv
// Shared types and constants of the round-robin schedule simulator.
package rrs_pkg;

    localparam int ARR_W       = 16;
    localparam int BURST_W     = 16;
    localparam int QNT_W       = 16;
    localparam int RES_W       = 21;
    localparam int IDX_OUT_W   = 6;
    localparam int S_TDATA_W   = 32;
    localparam int M_TDATA_W   = 72;
    localparam int M_USED_W    = IDX_OUT_W + 3 * RES_W;
    localparam logic [QNT_W-1:0] QUANTUM_RST = 16'd4;

    // sequencer states, one-hot
    typedef enum logic [11:0] {
        S_LOAD     = 12'b0000_0000_0001,
        S_ADM_RD   = 12'b0000_0000_0010,
        S_ADM_EV   = 12'b0000_0000_0100,
        S_CHECK    = 12'b0000_0000_1000,
        S_POP      = 12'b0000_0001_0000,
        S_RUN      = 12'b0000_0010_0000,
        S_REQ      = 12'b0000_0100_0000,
        S_MIN_RD   = 12'b0000_1000_0000,
        S_MIN_EV   = 12'b0001_0000_0000,
        S_OUT_RD   = 12'b0010_0000_0000,
        S_OUT_EV   = 12'b0100_0000_0000,
        S_OUT_WAIT = 12'b1000_0000_0000
    } state_t;

endpackage

### rtl/core/rrs_ring.sv
// FIFO ready queue of process indices with registered head read.
module rrs_ring #(
    parameter int DEPTH = 16,
    parameter int IW    = 4,
    parameter int CW    = 5
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          clear,
    input  logic          push,
    input  logic [IW-1:0] push_idx,
    input  logic          pop,
    output logic [IW-1:0] head_idx,
    output logic [CW-1:0] count
);

    logic [IW-1:0] ring_mem [DEPTH];
    logic [IW-1:0] head_reg, head_next;
    logic [IW-1:0] tail_reg, tail_next;
    logic [CW-1:0] count_reg, count_next;
    logic [IW-1:0] head_q;

    // pointer wrap at DEPTH
    always_comb begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (clear) begin
            head_next  = '0;
            tail_next  = '0;
            count_next = '0;
        end else begin
            if (push) begin
                tail_next = (tail_reg == IW'(DEPTH - 1)) ? '0 : tail_reg + IW'(1);
            end
            if (pop) begin
                head_next = (head_reg == IW'(DEPTH - 1)) ? '0 : head_reg + IW'(1);
            end
            if (push && !pop) begin
                count_next = count_reg + CW'(1);
            end else if (pop && !push) begin
                count_next = count_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // storage: one write, one registered read at the head
    always_ff @(posedge aclk) begin
        if (push && !clear) begin
            ring_mem[tail_reg] <= push_idx;
        end
        head_q <= ring_mem[head_reg];
    end

    assign head_idx = head_q;
    assign count    = count_reg;

endmodule

### rtl/core/round_robin_schedule_simulator.sv
// Top level: process store, slice sequencer and result output.
//
//  channel | dir | handshake          | payload
//  s_      | in  | s_tvalid/s_tready  | s_tdata {burst,arrival}, s_tlast last_process
//  m_      | out | m_tvalid/m_tready  | m_tdata {wait,turn,comp,index}, m_tlast last_result
//  cfg_    | in  | cfg_valid/cfg_ready| cfg_data quantum
//
// Loading: one item per cycle while s_tready is high. After the last item, an admission
// pass reads and evaluates each loaded process in turn; a slice is pop, run, pass,
// requeue, check, and an idle time jump is check, earliest-arrival scan, pass.
// Results go out one at a time, each held until m_tready. Synchronous reset, no
// clearing pass. s_tready is low from the last item until its final result is taken.
module round_robin_schedule_simulator
    import rrs_pkg::*;
#(
    parameter int MAX_PROCS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [15:0] arrival_time, [31:16] burst_time
    input  logic                 s_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [5:0] process_index, [26:6] completion_time, [47:27] turnaround_time,
    // [68:48] waiting_time, [71:69] zero
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tlast,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [QNT_W-1:0]     cfg_data
);

    `include "round_robin_schedule_simulator_defines.svh"

    localparam int IW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CW = $clog2(MAX_PROCS + 1);
    localparam int TW = 16 + CW;

    // process store
    logic [ARR_W-1:0]   arrival_mem    [MAX_PROCS];
    logic [BURST_W-1:0] burst_mem      [MAX_PROCS];
    logic [BURST_W-1:0] remaining_mem  [MAX_PROCS];
    logic [TW-1:0]      completion_mem [MAX_PROCS];
    logic [ARR_W-1:0]   arr_q;
    logic [BURST_W-1:0] burst_q, rem_q;
    logic [TW-1:0]      comp_q;

    state_t             state_reg, state_next;
    logic [QNT_W-1:0]   quantum_reg;
    logic [CW-1:0]      loaded_reg, loaded_next;
    logic [CW-1:0]      finished_reg, finished_next;
    logic [TW-1:0]      time_reg, time_next;
    logic [IW-1:0]      scan_reg, scan_next;
    logic [ARR_W-1:0]   min_arr_reg, min_arr_next;
    logic               found_reg, found_next;
    logic               adm_slice_reg, adm_slice_next;
    logic               skip_valid_reg, skip_valid_next;
    logic [IW-1:0]      cur_reg, cur_next;
    logic [BURST_W-1:0] rem_left_reg, rem_left_next;
    logic [MAX_PROCS-1:0] queued_reg, queued_next;
    logic               m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0] m_data_reg, m_data_next;
    logic               m_last_reg, m_last_next;

    logic               s_acc, room, scan_last;
    logic [IW-1:0]      rd_addr, load_addr;
    logic               ld_we, rem_we, comp_we;
    logic [BURST_W-1:0] rem_wdata;
    logic               ring_push, ring_pop, ring_clear;
    logic [IW-1:0]      ring_push_idx, ring_head;
    logic [CW-1:0]      ring_count;
    logic [QNT_W-1:0]   q_eff, run_len;
    logic               hit;
    logic               ran;
    logic [TW-1:0]      turn, wait_t;

    rrs_ring #(.DEPTH(MAX_PROCS), .IW(IW), .CW(CW)) u_ring (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .clear    (ring_clear),
        .push     (ring_push),
        .push_idx (ring_push_idx),
        .pop      (ring_pop),
        .head_idx (ring_head),
        .count    (ring_count)
    );

    assign s_tready  = (state_reg == S_LOAD);
    assign s_acc     = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign room      = (loaded_reg < CW'(MAX_PROCS));
    assign load_addr = loaded_reg[IW-1:0];
    assign scan_last = (CW'(scan_reg) == loaded_reg - CW'(1));
    assign q_eff     = (quantum_reg == '0) ? QNT_W'(1) : quantum_reg;
    assign run_len   = (rem_q < q_eff) ? rem_q : q_eff;
    assign hit       = (rem_q != '0) && (!found_reg || (arr_q < min_arr_reg));

    // result arithmetic
    assign ran    = (burst_q != '0) && (rem_q == '0);
    assign turn   = (comp_q >= TW'(arr_q)) ? comp_q - TW'(arr_q) : '0;
    assign wait_t = (turn > TW'(burst_q)) ? turn - TW'(burst_q) : '0;

    // quantum register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quantum_reg <= QUANTUM_RST;
        end else if (cfg_valid && cfg_ready) begin
            quantum_reg <= cfg_data;
        end
    end

    // sequencer
    always_comb begin
        state_next      = state_reg;
        loaded_next     = loaded_reg;
        finished_next   = finished_reg;
        time_next       = time_reg;
        scan_next       = scan_reg;
        min_arr_next    = min_arr_reg;
        found_next      = found_reg;
        adm_slice_next  = adm_slice_reg;
        skip_valid_next = skip_valid_reg;
        cur_next        = cur_reg;
        rem_left_next   = rem_left_reg;
        queued_next     = queued_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        m_last_next     = m_last_reg;
        rd_addr         = scan_reg;
        ld_we           = 1'b0;
        rem_we          = 1'b0;
        rem_wdata       = s_tdata[ARR_W +: BURST_W];
        comp_we         = 1'b0;
        ring_push       = 1'b0;
        ring_push_idx   = scan_reg;
        ring_pop        = 1'b0;
        ring_clear      = 1'b0;
        unique case (state_reg)
            S_LOAD: begin
                if (s_acc) begin
                    if (room) begin
                        ld_we       = 1'b1;
                        rem_we      = 1'b1;
                        queued_next[load_addr] = 1'b0;
                        loaded_next = loaded_reg + CW'(1);
                    end
                    if (s_tlast) begin
                        scan_next       = '0;
                        skip_valid_next = 1'b0;
                        adm_slice_next  = 1'b0;
                        state_next      = S_ADM_RD;
                    end
                end
            end
            S_ADM_RD: begin
                state_next = S_ADM_EV;
            end
            S_ADM_EV: begin
                if (!(skip_valid_reg && scan_reg == cur_reg) && TW'(arr_q) <= time_reg &&
                    rem_q != '0 && !queued_reg[scan_reg]) begin
                    ring_push             = 1'b1;
                    queued_next[scan_reg] = 1'b1;
                end
                if (scan_last) begin
                    state_next = adm_slice_reg ? S_REQ : S_CHECK;
                end else begin
                    scan_next  = scan_reg + IW'(1);
                    state_next = S_ADM_RD;
                end
            end
            S_CHECK: begin
                scan_next = '0;
                if (finished_reg == loaded_reg) begin
                    state_next = S_OUT_RD;
                end else if (ring_count == '0) begin
                    found_next = 1'b0;
                    state_next = S_MIN_RD;
                end else begin
                    state_next = S_POP;
                end
            end
            S_POP: begin
                ring_pop               = 1'b1;
                rd_addr                = ring_head;
                cur_next               = ring_head;
                queued_next[ring_head] = 1'b0;
                state_next             = S_RUN;
            end
            S_RUN: begin
                rd_addr         = cur_reg;
                rem_we          = 1'b1;
                rem_wdata       = rem_q - run_len;
                rem_left_next   = rem_q - run_len;
                time_next       = time_reg + TW'(run_len);
                skip_valid_next = 1'b1;
                adm_slice_next  = 1'b1;
                scan_next       = '0;
                state_next      = S_ADM_RD;
            end
            S_REQ: begin
                if (rem_left_reg != '0) begin
                    ring_push            = 1'b1;
                    ring_push_idx        = cur_reg;
                    queued_next[cur_reg] = 1'b1;
                end else begin
                    comp_we       = 1'b1;
                    finished_next = finished_reg + CW'(1);
                end
                skip_valid_next = 1'b0;
                state_next      = S_CHECK;
            end
            S_MIN_RD: begin
                state_next = S_MIN_EV;
            end
            S_MIN_EV: begin
                if (hit) begin
                    min_arr_next = arr_q;
                    found_next   = 1'b1;
                end
                if (scan_last) begin
                    scan_next = '0;
                    if (!(found_reg || hit)) begin
                        state_next = S_OUT_RD;
                    end else begin
                        if (TW'(min_arr_next) > time_reg) begin
                            time_next = TW'(min_arr_next);
                        end
                        adm_slice_next = 1'b0;
                        state_next     = S_ADM_RD;
                    end
                end else begin
                    scan_next  = scan_reg + IW'(1);
                    state_next = S_MIN_RD;
                end
            end
            S_OUT_RD: begin
                state_next = S_OUT_EV;
            end
            S_OUT_EV: begin
                m_data_next = '0;
                m_data_next[IDX_OUT_W-1:0] = IDX_OUT_W'(scan_reg);
                if (ran) begin
                    m_data_next[IDX_OUT_W +: RES_W]             = RES_W'(comp_q);
                    m_data_next[IDX_OUT_W + RES_W +: RES_W]     = RES_W'(turn);
                    m_data_next[IDX_OUT_W + 2 * RES_W +: RES_W] = RES_W'(wait_t);
                end
                m_last_next  = scan_last;
                m_valid_next = 1'b1;
                state_next   = S_OUT_WAIT;
            end
            S_OUT_WAIT: begin
                if (m_tready) begin
                    m_valid_next = 1'b0;
                    if (m_last_reg) begin
                        ring_clear    = 1'b1;
                        loaded_next   = '0;
                        finished_next = '0;
                        time_next     = '0;
                        queued_next   = '0;
                        state_next    = S_LOAD;
                    end else begin
                        scan_next  = scan_reg + IW'(1);
                        state_next = S_OUT_RD;
                    end
                end
            end
            default: begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_LOAD;
            loaded_reg     <= '0;
            finished_reg   <= '0;
            time_reg       <= '0;
            scan_reg       <= '0;
            found_reg      <= 1'b0;
            adm_slice_reg  <= 1'b0;
            skip_valid_reg <= 1'b0;
            queued_reg     <= '0;
            m_valid_reg    <= 1'b0;
            m_last_reg     <= 1'b0;
        end else begin
            state_reg      <= state_next;
            loaded_reg     <= loaded_next;
            finished_reg   <= finished_next;
            time_reg       <= time_next;
            scan_reg       <= scan_next;
            found_reg      <= found_next;
            adm_slice_reg  <= adm_slice_next;
            skip_valid_reg <= skip_valid_next;
            queued_reg     <= queued_next;
            m_valid_reg    <= m_valid_next;
            m_last_reg     <= m_last_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        min_arr_reg  <= min_arr_next;
        cur_reg      <= cur_next;
        rem_left_reg <= rem_left_next;
        m_data_reg   <= m_data_next;
    end

    // store writes and registered reads
    always_ff @(posedge aclk) begin
        if (ld_we) begin
            arrival_mem[load_addr] <= s_tdata[ARR_W-1:0];
            burst_mem[load_addr]   <= s_tdata[ARR_W +: BURST_W];
        end
        if (rem_we) begin
            remaining_mem[ld_we ? load_addr : cur_reg] <= rem_wdata;
        end
        if (comp_we) begin
            completion_mem[cur_reg] <= time_reg;
        end
        arr_q   <= arrival_mem[rd_addr];
        burst_q <= burst_mem[rd_addr];
        rem_q   <= remaining_mem[rd_addr];
        comp_q  <= completion_mem[rd_addr];
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    // checks
    `RRS_ASSERT_ALWAYS(a_fin_le_loaded, aclk, aresetn, finished_reg <= loaded_reg)
    `RRS_ASSERT_ALWAYS(a_ring_le_max, aclk, aresetn, ring_count <= CW'(MAX_PROCS))
    `RRS_ASSERT_IMPLY(a_run_has_work, aclk, aresetn, state_reg == S_RUN, rem_q != '0)
    `RRS_ASSERT_IMPLY(a_ready_no_out, aclk, aresetn, s_tready, !m_tvalid)

endmodule

### tb/testbench.sv
// Self-checking testbench for the round-robin schedule simulator.
module testbench;
    import rrs_pkg::*;

    localparam int NPROC = 16;

    typedef struct packed {
        logic [ARR_W-1:0]   arrival;
        logic [BURST_W-1:0] burst;
        logic               last;
    } proc_item_t;

    typedef struct packed {
        logic [IDX_OUT_W-1:0] index;
        logic [RES_W-1:0]     comp;
        logic [RES_W-1:0]     turn;
        logic [RES_W-1:0]     wait_t;
        logic                 last;
    } report_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 s_tlast;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [QNT_W-1:0]     cfg_data;

    round_robin_schedule_simulator #(.MAX_PROCS(NPROC)) dut (.*);

    // predictor state
    logic [QNT_W-1:0] slice_len;
    int unsigned      arr_q[NPROC];
    int unsigned      bst_q[NPROC];
    int unsigned      rem_q[NPROC];
    int unsigned      done_at[NPROC];
    bit               in_ring[NPROC];
    int unsigned      ring[$];
    int unsigned      now_t;
    int unsigned      n_loaded;

    proc_item_t pending_items[$];
    report_t    expected_reports[$];
    int         fail_count;
    int         send_idle_pct;
    int         recv_idle_pct;

    // queue every ready, unfinished, unqueued process except skip, by index
    function automatic void admit_ready(int skip);
        for (int i = 0; i < n_loaded; i++)
            if (i != skip && arr_q[i] <= now_t && rem_q[i] > 0 && !in_ring[i]) begin
                ring.push_back(i);
                in_ring[i] = 1;
            end
    endfunction

    function automatic void run_schedule();
        int unsigned q, nxt, p, run, finished;
        bit found;
        q = (slice_len == 0) ? 1 : slice_len;
        finished = 0;
        admit_ready(NPROC);
        while (finished < n_loaded) begin
            if (ring.size() == 0) begin
                found = 0;
                nxt = 0;
                for (int i = 0; i < n_loaded; i++)
                    if (rem_q[i] > 0 && (!found || arr_q[i] < nxt)) begin
                        nxt = arr_q[i];
                        found = 1;
                    end
                if (!found) break;
                if (nxt > now_t) now_t = nxt;
                admit_ready(NPROC);
                continue;
            end
            p = ring.pop_front();
            in_ring[p] = 0;
            run = rem_q[p] < q ? rem_q[p] : q;
            now_t += run;
            rem_q[p] -= run;
            admit_ready(p);
            if (rem_q[p] > 0) begin
                ring.push_back(p);
                in_ring[p] = 1;
            end else begin
                finished++;
                done_at[p] = now_t;
            end
        end
    endfunction

    // predict reports for one accepted process item
    function automatic void predict_process(proc_item_t it);
        report_t r;
        int unsigned c, t, w;
        if (n_loaded < NPROC) begin
            arr_q[n_loaded] = it.arrival;
            bst_q[n_loaded] = it.burst;
            rem_q[n_loaded] = it.burst;
            done_at[n_loaded] = 0;
            in_ring[n_loaded] = 0;
            n_loaded++;
        end
        if (!it.last) return;
        run_schedule();
        for (int i = 0; i < n_loaded; i++) begin
            c = 0; t = 0; w = 0;
            if (bst_q[i] > 0 && rem_q[i] == 0) begin
                c = done_at[i];
                t = c >= arr_q[i] ? c - arr_q[i] : 0;
                w = t > bst_q[i] ? t - bst_q[i] : 0;
            end
            r.index  = IDX_OUT_W'(i);
            r.comp   = RES_W'(c);
            r.turn   = RES_W'(t);
            r.wait_t = RES_W'(w);
            r.last   = (i + 1 == n_loaded);
            expected_reports.push_back(r);
        end
        for (int i = 0; i < NPROC; i++) in_ring[i] = 0;
        ring.delete();
        now_t = 0;
        n_loaded = 0;
    endfunction

    initial begin
        aclk = 0;
        forever #1 aclk = ~aclk;
    end

    // driver
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 0;
        end else if (!s_tvalid || s_tready) begin
            // s_tready only changes at the rising edge, so it holds for the coming edge
            if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                s_tvalid <= 1;
                s_tdata  <= {pending_items[0].burst, pending_items[0].arrival};
                s_tlast  <= pending_items[0].last;
            end else begin
                s_tvalid <= 0;
            end
        end
    end

    // take accepted items off the pending queue and predict
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            predict_process(pending_items.pop_front());
        end
    end

    // receiver stalls
    always @(negedge aclk) begin
        m_tready <= aresetn && ($urandom_range(99) >= recv_idle_pct);
    end

    // monitor
    always @(posedge aclk) begin
        report_t got, exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            got.index  = m_tdata[5:0];
            got.comp   = m_tdata[26:6];
            got.turn   = m_tdata[47:27];
            got.wait_t = m_tdata[68:48];
            got.last   = m_tlast;
            if (expected_reports.size() == 0) begin
                $error("unexpected report index %0d", got.index);
                fail_count++;
            end else begin
                exp_r = expected_reports.pop_front();
                if (got.index != exp_r.index) begin
                    $error("process_index exp %0d got %0d", exp_r.index, got.index);
                    fail_count++;
                end
                if (got.comp != exp_r.comp) begin
                    $error("completion_time exp %0d got %0d", exp_r.comp, got.comp);
                    fail_count++;
                end
                if (got.turn != exp_r.turn) begin
                    $error("turnaround_time exp %0d got %0d", exp_r.turn, got.turn);
                    fail_count++;
                end
                if (got.wait_t != exp_r.wait_t) begin
                    $error("waiting_time exp %0d got %0d", exp_r.wait_t, got.wait_t);
                    fail_count++;
                end
                if (got.last != exp_r.last) begin
                    $error("last_result exp %0d got %0d", exp_r.last, got.last);
                    fail_count++;
                end
            end
        end
    end

    function automatic void add_proc(int a, int b, bit l);
        proc_item_t it;
        it.arrival = ARR_W'(a);
        it.burst   = BURST_W'(b);
        it.last    = l;
        pending_items.push_back(it);
    endfunction

    // one random process set; mostly small times, sometimes full range
    // (full-range bursts only with a large quantum, to bound the slice count)
    function automatic void add_random_set(int n);
        int a, b;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(9) == 0) begin
                a = $urandom_range(65535);
                b = (slice_len >= 16'd1024) ? $urandom_range(65535) : $urandom_range(1024);
            end else begin
                a = $urandom_range(40);
                b = ($urandom_range(7) == 0) ? 0 : $urandom_range(1, 20);
            end
            add_proc(a, b, i == n - 1);
        end
    endfunction

    task automatic wait_drained();
        while (pending_items.size() > 0 || expected_reports.size() > 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_quantum(logic [QNT_W-1:0] v);
        @(negedge aclk);
        cfg_valid <= 1;
        cfg_data  <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 0;
        slice_len = v;
    endtask

    initial begin
        fail_count = 0;
        send_idle_pct = 29;
        recv_idle_pct = 60;
        slice_len = QUANTUM_RST;
        n_loaded = 0;
        now_t = 0;
        aresetn = 0;
        s_tvalid = 0;
        s_tdata = 0;
        s_tlast = 0;
        m_tready = 0;
        cfg_valid = 0;
        cfg_data = 0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;

        // directed: reset quantum, gaps, zero burst, single process
        add_proc(0, 5, 0);
        add_proc(3, 0, 0);
        add_proc(10, 2, 0);
        add_proc(1, 9, 1);
        add_proc(7, 0, 1);
        add_proc(100, 3, 1);
        wait_drained();
        // full-scale fields; then overflow past capacity with quantum zero
        write_quantum(16'hFFFF);
        add_proc(16'hFFFF, 16'hFFFF, 0);
        add_proc(0, 16'hFFFF, 0);
        add_proc(16'h5555, 16'hAAAA, 1);
        wait_drained();
        write_quantum(0);
        for (int i = 0; i < 18; i++) add_proc(i, (i * 3) % 7, i == 17);
        wait_drained();
        write_quantum(1);

        // random sets across quantum settings and idle profiles
        for (int ph = 0; ph < 3; ph++) begin
            if (ph == 1) begin send_idle_pct = 60; recv_idle_pct = 29; end
            if (ph == 2) begin send_idle_pct = 0;  recv_idle_pct = 0;  end
            for (int s = 0; s < 5; s++) begin
                int n;
                n = $urandom_range(1, 17);
                add_random_set(n);
                if (s == 3) begin
                    wait_drained();
                    write_quantum(($urandom_range(3) == 0) ? QNT_W'($urandom_range(65535))
                                                           : QNT_W'($urandom_range(1, 8)));
                end
            end
            wait_drained();
        end
        if (fail_count == 0)
            $display("[round_robin_schedule_simulator] OK");
        else
            $display("[round_robin_schedule_simulator] ERROR");
        $finish;
    end

    // watchdog
    initial begin
        #60000000;
        $display("[round_robin_schedule_simulator] ERROR");
        $finish;
    end
endmodule
